// ===== rtl/homogeneous_monomial_enumerator_assert.svh =====
// Assertion macros for the monomial enumerator.
// Both macros sample on the rising edge of the given clock and are
// disabled while the given active-low reset is asserted.
`ifndef HOMOGENEOUS_MONOMIAL_ENUMERATOR_ASSERT_SVH
`define HOMOGENEOUS_MONOMIAL_ENUMERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define HME_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define HME_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HME_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HME_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/hme_pkg.sv =====
`default_nettype none
package hme_pkg;

  localparam int MAX_VARS   = 16;
  localparam int FREE_N     = MAX_VARS - 1;
  localparam int EXP_W      = 8;
  localparam int VAR_W      = 5;
  localparam int POS_W      = $clog2(MAX_VARS);
  localparam int IDX_W      = (FREE_N > 1) ? $clog2(FREE_N) : 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VAR_COUNT = CFG_IDX_W'(0),
    REG_DEGREE    = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_ADV,
    ST_SEARCH,
    ST_DROP,
    ST_INC_K,
    ST_INC_SUM
  } state_e;

  typedef enum logic {
    ALU_INC,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [EXP_W-1:0] a;
    logic [EXP_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [EXP_W-1:0] res;
    logic             eq;
    logic             lt;
  } alu_rsp_t;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [EXP_W-1:0] wdata;
    logic             sum_we;
    logic [EXP_W-1:0] sum_wdata;
    logic [IDX_W-1:0] raddr;
  } store_cmd_t;

  typedef struct packed {
    logic [EXP_W-1:0] rdata;
    logic [EXP_W-1:0] sum;
  } store_rsp_t;

  typedef struct packed {
    logic [VAR_W-1:0] var_count;
    logic [EXP_W-1:0] degree;
    logic             wr;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [EXP_W-1:0] exponent;
    logic [POS_W-1:0] pos;
    logic             eom;
    logic             last;
  } emit_t;

endpackage
`default_nettype wire

// ===== rtl/hme_in_if.sv =====
`default_nettype none
interface hme_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

// ===== rtl/hme_out_if.sv =====
`default_nettype none
interface hme_out_if;
  logic                       valid;
  logic                       ready;
  logic [hme_pkg::EXP_W-1:0]  exponent;
  logic [hme_pkg::POS_W-1:0]  var_position;
  logic                       end_of_monomial;
  logic                       last_monomial;

  modport source (output valid, output exponent, output var_position,
                  output end_of_monomial, output last_monomial, input ready);
  modport sink   (input valid, input exponent, input var_position,
                  input end_of_monomial, input last_monomial, output ready);
endinterface
`default_nettype wire

// ===== rtl/hme_cfg_if.sv =====
`default_nettype none
interface hme_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hme_pkg::CFG_IDX_W-1:0]  index;
  logic [hme_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/homogeneous_monomial_enumerator.sv =====
`default_nettype none
// Homogeneous monomial enumerator. Every accepted request word emits the current
// exponent vector of var_count variables (clamped to 1..16) whose exponents sum to
// degree, as one result word per variable with position 0 first, and then steps to
// the next vector in lexicographic order of the free exponents; the final vector,
// [degree, 0, ..., 0], is flagged last_monomial on all of its words and wraps back to
// the first. A request with restart set, and any write to var_count or degree,
// returns to the first monomial. The block works on one request at a time: it emits
// the n words of a request, then steps to the next vector; a step that has to search
// back for the last nonzero free exponent reads the free exponents one at a time,
// since a single 8-bit add/compare unit and one read port on the exponent registers
// serve every step of the sequencer. The result words leave through an output
// register, so the last word may wait on the sink while the block finishes its step
// and accepts the next request. Configuration writes are always ready and must come
// while no request is in flight.
module homogeneous_monomial_enumerator (
  input  logic             clk_i,
  input  logic             rst_ni,
  hme_in_if.sink           in_i,
  hme_out_if.source        out_o,
  hme_cfg_if.sink          cfg_i
);

  logic [hme_pkg::VAR_W-1:0] var_count_q;
  logic [hme_pkg::EXP_W-1:0] degree_q;
  logic                      cfg_wr;

  hme_pkg::cfg_t       cfg;
  hme_pkg::emit_t      emit;
  hme_pkg::store_cmd_t store_cmd;
  hme_pkg::store_rsp_t store_rsp;
  hme_pkg::alu_req_t   alu_req;
  hme_pkg::alu_rsp_t   alu_rsp;

  logic                      out_valid_q;
  logic [hme_pkg::EXP_W-1:0] out_exp_q;
  logic [hme_pkg::POS_W-1:0] out_pos_q;
  logic                      out_eom_q;
  logic                      out_last_q;
  logic                      out_free;

  // Configuration: writes to unknown indexes are dropped and do not restart.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    unique case (cfg_i.index)
      hme_pkg::REG_VAR_COUNT,
      hme_pkg::REG_DEGREE: cfg_wr = cfg_i.valid;
      default:             cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= hme_pkg::VAR_W'(1);
      degree_q    <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == hme_pkg::REG_VAR_COUNT) begin
        var_count_q <= cfg_i.data[hme_pkg::VAR_W-1:0];
      end
      if (cfg_i.index == hme_pkg::REG_DEGREE) begin
        degree_q <= cfg_i.data[hme_pkg::EXP_W-1:0];
      end
    end
  end

  assign cfg.var_count = var_count_q;
  assign cfg.degree    = degree_q;
  assign cfg.wr        = cfg_wr;

  hme_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_i.ready),
    .out_free_i   (out_free),
    .emit_o       (emit),
    .store_o      (store_cmd),
    .store_i      (store_rsp),
    .alu_o        (alu_req),
    .alu_i        (alu_rsp)
  );

  hme_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (store_cmd),
    .rsp_o  (store_rsp)
  );

  hme_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Output register: a new word loads when the slot is empty or being taken.
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_exp_q  <= emit.exponent;
      out_pos_q  <= emit.pos;
      out_eom_q  <= emit.eom;
      out_last_q <= emit.last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.exponent        = out_exp_q;
  assign out_o.var_position    = out_pos_q;
  assign out_o.end_of_monomial = out_eom_q;
  assign out_o.last_monomial   = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/hme_alu.sv =====
`default_nettype none
// Shared 8-bit unit: increment, or subtract with equal and borrow flags.
module hme_alu (
  input  hme_pkg::alu_req_t req_i,
  output hme_pkg::alu_rsp_t rsp_o
);

  logic [hme_pkg::EXP_W-1:0] b_op;
  logic [hme_pkg::EXP_W:0]   total;

  always_comb begin
    case (req_i.op)
      hme_pkg::ALU_SUB: b_op = ~req_i.b;
      default:          b_op = '0;
    endcase
  end

  assign total     = {1'b0, req_i.a} + {1'b0, b_op} + {{hme_pkg::EXP_W{1'b0}}, 1'b1};
  assign rsp_o.res = total[hme_pkg::EXP_W-1:0];
  assign rsp_o.eq  = (total[hme_pkg::EXP_W-1:0] == '0);
  assign rsp_o.lt  = (req_i.op == hme_pkg::ALU_SUB) && !total[hme_pkg::EXP_W];

endmodule
`default_nettype wire

// ===== rtl/hme_store.sv =====
`default_nettype none
// Free-exponent registers and running sum: one read port, one write port.
module hme_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hme_pkg::store_cmd_t cmd_i,
  output hme_pkg::store_rsp_t rsp_o
);

  logic [hme_pkg::EXP_W-1:0] fe_q [hme_pkg::FREE_N];
  logic [hme_pkg::EXP_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hme_pkg::FREE_N; i++) begin
        fe_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (cmd_i.clr) begin
      for (int i = 0; i < hme_pkg::FREE_N; i++) begin
        fe_q[i] <= '0;
      end
      sum_q <= '0;
    end else begin
      if (cmd_i.we && (cmd_i.waddr < hme_pkg::FREE_N)) begin
        fe_q[cmd_i.waddr] <= cmd_i.wdata;
      end
      if (cmd_i.sum_we) begin
        sum_q <= cmd_i.sum_wdata;
      end
    end
  end

  assign rsp_o.rdata = (cmd_i.raddr < hme_pkg::FREE_N) ? fe_q[cmd_i.raddr] : '0;
  assign rsp_o.sum   = sum_q;

endmodule
`default_nettype wire

// ===== rtl/hme_ctrl.sv =====
`default_nettype none
`include "homogeneous_monomial_enumerator_assert.svh"
// Sequencer: one word per cycle while the output is free, then an exponent step.
module hme_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hme_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  input  logic                in_restart_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output hme_pkg::emit_t      emit_o,
  output hme_pkg::store_cmd_t store_o,
  input  hme_pkg::store_rsp_t store_i,
  output hme_pkg::alu_req_t   alu_o,
  input  hme_pkg::alu_rsp_t   alu_i
);

  hme_pkg::state_e           state_q, state_d;
  logic [hme_pkg::POS_W-1:0] j_q, j_d;
  logic [hme_pkg::IDX_W-1:0] k_q, k_d;
  logic                      last_q, last_d;
  logic [hme_pkg::POS_W-1:0] nfree;
  logic                      at_end;

  // Number of free exponents: active variables minus one, after clamping.
  always_comb begin
    if (cfg_i.var_count == '0) begin
      nfree = '0;
    end else if (cfg_i.var_count > hme_pkg::MAX_VARS) begin
      nfree = hme_pkg::POS_W'(hme_pkg::MAX_VARS - 1);
    end else begin
      nfree = hme_pkg::POS_W'(cfg_i.var_count - 1'b1);
    end
  end

  assign at_end = (j_q == nfree);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hme_pkg::ST_IDLE;
      j_q     <= '0;
      k_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      k_q     <= k_d;
      last_q  <= last_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    k_d     = k_q;
    last_d  = last_q;
    unique case (state_q)
      hme_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = hme_pkg::ST_CHECK;
        end
      end
      hme_pkg::ST_CHECK: begin
        last_d  = (nfree == '0) || alu_i.eq;
        j_d     = '0;
        state_d = hme_pkg::ST_EMIT;
      end
      hme_pkg::ST_EMIT: begin
        if (out_free_i) begin
          if (at_end) begin
            state_d = ((nfree == '0) || last_q) ? hme_pkg::ST_IDLE : hme_pkg::ST_ADV;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      hme_pkg::ST_ADV: begin
        k_d     = hme_pkg::IDX_W'(nfree - 1'b1);
        state_d = alu_i.lt ? hme_pkg::ST_INC_K : hme_pkg::ST_SEARCH;
      end
      hme_pkg::ST_SEARCH: begin
        if (k_q == '0) begin
          state_d = hme_pkg::ST_IDLE;
        end else if (alu_i.eq) begin
          k_d = k_q - 1'b1;
        end else begin
          state_d = hme_pkg::ST_DROP;
        end
      end
      hme_pkg::ST_DROP: begin
        k_d     = k_q - 1'b1;
        state_d = hme_pkg::ST_INC_K;
      end
      hme_pkg::ST_INC_K: begin
        state_d = hme_pkg::ST_INC_SUM;
      end
      hme_pkg::ST_INC_SUM: begin
        state_d = hme_pkg::ST_IDLE;
      end
      default: begin
        state_d = hme_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: store port, shared unit operands and the result word.
  always_comb begin
    in_ready_o      = 1'b0;
    store_o         = '0;
    store_o.raddr   = k_q;
    store_o.clr     = cfg_i.wr;
    alu_o.op        = hme_pkg::ALU_INC;
    alu_o.a         = store_i.rdata;
    alu_o.b         = '0;
    emit_o.load     = 1'b0;
    emit_o.exponent = store_i.rdata;
    emit_o.pos      = j_q;
    emit_o.eom      = at_end;
    emit_o.last     = last_q;
    unique case (state_q)
      hme_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_restart_i) begin
          store_o.clr = 1'b1;
        end
      end
      hme_pkg::ST_CHECK: begin
        store_o.raddr = '0;
        alu_o.op      = hme_pkg::ALU_SUB;
        alu_o.b       = cfg_i.degree;
      end
      hme_pkg::ST_EMIT: begin
        store_o.raddr = hme_pkg::IDX_W'(j_q);
        // The last variable takes whatever the free exponents leave over.
        alu_o.op      = hme_pkg::ALU_SUB;
        alu_o.a       = cfg_i.degree;
        alu_o.b       = (nfree == '0) ? '0 : store_i.sum;
        if (at_end) begin
          emit_o.exponent = alu_i.res;
        end
        emit_o.load = out_free_i;
        // The final monomial wraps to the first; a single variable keeps its state.
        if (out_free_i && at_end && last_q && (nfree != '0)) begin
          store_o.clr = 1'b1;
        end
      end
      hme_pkg::ST_ADV: begin
        alu_o.op = hme_pkg::ALU_SUB;
        alu_o.a  = store_i.sum;
        alu_o.b  = cfg_i.degree;
      end
      hme_pkg::ST_SEARCH: begin
        alu_o.op = hme_pkg::ALU_SUB;
        if (k_q == '0) begin
          store_o.clr = 1'b1;
        end
      end
      hme_pkg::ST_DROP: begin
        alu_o.op          = hme_pkg::ALU_SUB;
        alu_o.a           = store_i.sum;
        alu_o.b           = store_i.rdata;
        store_o.sum_we    = 1'b1;
        store_o.sum_wdata = alu_i.res;
        store_o.we        = 1'b1;
        store_o.waddr     = k_q;
        store_o.wdata     = '0;
      end
      hme_pkg::ST_INC_K: begin
        store_o.we    = 1'b1;
        store_o.waddr = k_q;
        store_o.wdata = alu_i.res;
      end
      hme_pkg::ST_INC_SUM: begin
        alu_o.a           = store_i.sum;
        store_o.sum_we    = 1'b1;
        store_o.sum_wdata = alu_i.res;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `HME_ASSERT_IMP(a_sum_le_deg, clk_i, rst_ni, state_q == hme_pkg::ST_IDLE, !alu_i.lt || state_q != hme_pkg::ST_IDLE, "idle")
  `HME_ASSERT_IMP(a_drop_nobrw, clk_i, rst_ni, state_q == hme_pkg::ST_DROP, !alu_i.lt, "running sum below exponent")
  `HME_ASSERT_IMP(a_search_k, clk_i, rst_ni, state_q == hme_pkg::ST_SEARCH, k_q < nfree, "search index out of range")
  `HME_ASSERT_NXT(a_eom_leaves, clk_i, rst_ni, emit_o.load && emit_o.eom, state_q != hme_pkg::ST_EMIT, "emit overran")
  `HME_ASSERT_IMP(a_idle_sum, clk_i, rst_ni, state_q == hme_pkg::ST_IDLE, store_i.sum <= cfg_i.degree, "sum over degree")

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the homogeneous monomial enumerator.
//
// Three handshake channels surround the block: request words (restart flag),
// result words (one per variable of the current monomial) and register writes.
// Clocked driver blocks feed the request and register channels from queues that
// the main initial block fills, phase by phase. Between phases the main block
// waits until every expected result word has arrived and the block has had time
// to finish its internal step, and only then touches the registers.
//
// A monitor block watches all three channels. Each accepted request runs through
// a local model of the enumerator, which queues the expected result words. Each
// accepted result word is checked against the oldest expected one, field by field.
module tb_top;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 180;
  // The block may still be stepping after its last result word has left, so
  // give it this long before a register write.
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 1000;

  // Register indexes that the block does not decode. A write to one of them
  // must leave the enumeration alone.
  localparam logic [hme_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = hme_pkg::CFG_IDX_W'(2);
  localparam logic [hme_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = hme_pkg::CFG_IDX_W'(3);

  // How often the two sides pause.
  localparam int IDLE_OFF   = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  typedef struct packed {
    logic [hme_pkg::EXP_W-1:0] exponent;
    logic [hme_pkg::POS_W-1:0] var_position;
    logic                      end_of_monomial;
    logic                      last_monomial;
  } mono_word_t;

  typedef struct packed {
    logic [hme_pkg::CFG_IDX_W-1:0]  index;
    logic [hme_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hme_in_if  in_if ();
  hme_out_if out_if ();
  hme_cfg_if cfg_if ();

  homogeneous_monomial_enumerator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Pending stimulus and the words the model says must come out.
  logic       restart_q[$];
  reg_write_t reg_write_q[$];
  mono_word_t mono_words_q[$];

  int idle_mode      = IDLE_LIGHT;
  int items_queued   = 0;
  int items_accepted = 0;
  int writes_queued  = 0;
  int writes_done    = 0;
  int words_checked  = 0;
  int last_words     = 0;
  int error_count    = 0;
  int stuck_cycles   = 0;
  int in_gap         = 0;
  int out_stall      = 0;

  // Local copy of the enumerator state and its two registers.
  logic [hme_pkg::VAR_W-1:0] cur_var_count;
  logic [hme_pkg::EXP_W-1:0] cur_degree;
  logic [hme_pkg::EXP_W-1:0] free_exp[hme_pkg::MAX_VARS-1];
  logic [hme_pkg::EXP_W-1:0] run_sum;

  // Every block input has a known value from time zero on.
  initial begin
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
  end

  // ---------------------------------------------------------------------------
  // Model of the enumerator
  // ---------------------------------------------------------------------------

  task automatic clear_vector();
    for (int i = 0; i < hme_pkg::MAX_VARS - 1; i++) free_exp[i] = '0;
    run_sum = '0;
  endtask

  // Any decoded register write also sends the enumeration back to its start.
  task automatic apply_register(input logic [hme_pkg::CFG_IDX_W-1:0] idx,
                                input logic [hme_pkg::CFG_DATA_W-1:0] data);
    if (idx == hme_pkg::REG_VAR_COUNT) begin
      cur_var_count = data[hme_pkg::VAR_W-1:0];
      clear_vector();
    end else if (idx == hme_pkg::REG_DEGREE) begin
      cur_degree = data[hme_pkg::EXP_W-1:0];
      clear_vector();
    end
  endtask

  // Emits the current monomial as expected words, then steps the free
  // exponents to the next vector in lexicographic order.
  task automatic predict_monomial(input logic restart_bit);
    int unsigned n;
    int unsigned nfree;
    int unsigned k;
    logic        is_last;
    mono_word_t  w;
    // A count of zero acts as one variable; anything above the maximum saturates.
    if (cur_var_count == 0) n = 1;
    else if (cur_var_count > hme_pkg::MAX_VARS) n = hme_pkg::MAX_VARS;
    else n = cur_var_count;
    nfree = n - 1;
    if (restart_bit) clear_vector();
    if (nfree == 0) begin
      // One variable: its exponent is the whole degree and it is always last.
      w.exponent        = cur_degree;
      w.var_position    = '0;
      w.end_of_monomial = 1'b1;
      w.last_monomial   = 1'b1;
      mono_words_q = {mono_words_q, w};
    end else begin
      // The final vector is [degree, 0, ..., 0]; with zero degree the only
      // vector is all zero, so it is final every time.
      is_last = (free_exp[0] == cur_degree);
      for (int unsigned j = 0; j < n; j++) begin
        if (j < nfree) w.exponent = free_exp[j];
        else w.exponent = hme_pkg::EXP_W'(cur_degree - run_sum);
        w.var_position    = hme_pkg::POS_W'(j);
        w.end_of_monomial = (j == n - 1);
        w.last_monomial   = is_last;
        mono_words_q = {mono_words_q, w};
      end
      if (is_last) begin
        clear_vector();
      end else if (run_sum < cur_degree) begin
        free_exp[nfree-1] = free_exp[nfree-1] + 1'b1;
        run_sum           = run_sum + 1'b1;
      end else begin
        // Sum is full: clear the last nonzero free exponent, carry into its
        // left neighbor.
        k = nfree - 1;
        while (k > 0 && free_exp[k] == 0) k--;
        if (k == 0) begin
          clear_vector();
        end else begin
          run_sum       = hme_pkg::EXP_W'(run_sum - free_exp[k] + 1'b1);
          free_exp[k]   = '0;
          free_exp[k-1] = free_exp[k-1] + 1'b1;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_word(input mono_word_t got);
    mono_word_t want;
    if (mono_words_q.size() == 0) begin
      report_mismatch($sformatf("result word with nothing expected (exp %0d pos %0d)",
                                got.exponent, got.var_position));
    end else begin
      want = mono_words_q.pop_front();
      if (got.exponent !== want.exponent)
        report_mismatch($sformatf("exponent %0d, expected %0d at pos %0d",
                                  got.exponent, want.exponent, want.var_position));
      if (got.var_position !== want.var_position)
        report_mismatch($sformatf("var_position %0d, expected %0d",
                                  got.var_position, want.var_position));
      if (got.end_of_monomial !== want.end_of_monomial)
        report_mismatch($sformatf("end_of_monomial %b, expected %b at pos %0d",
                                  got.end_of_monomial, want.end_of_monomial,
                                  want.var_position));
      if (got.last_monomial !== want.last_monomial)
        report_mismatch($sformatf("last_monomial %b, expected %b at pos %0d",
                                  got.last_monomial, want.last_monomial,
                                  want.var_position));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Request driver. A new word is offered only once the previous one has been
  // taken, and a random pause may come in between.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.restart <= 1'b0;
      in_gap        <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_gap != 0) begin
        in_if.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (restart_q.size() != 0 && idle_mode != IDLE_OFF &&
                   $urandom_range(0, (idle_mode == IDLE_HEAVY) ? 3 : 15) == 0) begin
        in_if.valid <= 1'b0;
        in_gap      <= $urandom_range(0, 18);
      end else if (restart_q.size() != 0) begin
        in_if.valid   <= 1'b1;
        in_if.restart <= restart_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink. Ready drops for random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_stall != 0) begin
      out_if.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else if (idle_mode != IDLE_OFF &&
                 $urandom_range(0, (idle_mode == IDLE_HEAVY) ? 3 : 15) == 0) begin
      out_if.ready <= 1'b0;
      out_stall    <= $urandom_range(0, 18);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Register write driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_if.valid <= 1'b0;
      cfg_if.index <= '0;
      cfg_if.data  <= '0;
    end else if (!cfg_if.valid || cfg_if.ready) begin
      if (reg_write_q.size() != 0) begin
        cfg_if.valid <= 1'b1;
        cfg_if.index <= reg_write_q[0].index;
        cfg_if.data  <= reg_write_q[0].data;
        reg_write_q.delete(0);
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and watchdog
  // ---------------------------------------------------------------------------

  // Result words are checked before a request accepted on the same edge is
  // modeled, since that request cannot have produced anything yet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        check_word('{exponent:        out_if.exponent,
                     var_position:    out_if.var_position,
                     end_of_monomial: out_if.end_of_monomial,
                     last_monomial:   out_if.last_monomial});
        words_checked++;
        if (out_if.last_monomial) last_words++;
      end
      if (in_if.valid && in_if.ready) begin
        predict_monomial(in_if.restart);
        items_accepted++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_register(cfg_if.index, cfg_if.data);
        writes_done++;
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no word moved for %0d cycles", $time, stuck_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing (runs on the falling edge, clear of the drivers)
  // ---------------------------------------------------------------------------

  task automatic push_item(input logic restart_bit);
    restart_q = {restart_q, restart_bit};
    items_queued++;
  endtask

  // Waits until every request has been taken and every result word has come,
  // then lets the block finish its step.
  task automatic wait_drained();
    while (items_accepted != items_queued || mono_words_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Only called with the block drained.
  task automatic write_register(input logic [hme_pkg::CFG_IDX_W-1:0] idx,
                                input logic [hme_pkg::CFG_DATA_W-1:0] data);
    reg_write_t wr;
    wr.index    = idx;
    wr.data     = data;
    reg_write_q = {reg_write_q, wr};
    writes_queued++;
    while (writes_done != writes_queued) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int                        random_items;
    int                        phase_items;
    int                        sel;
    int                        which;
    logic [7:0]                vc_data;
    logic [hme_pkg::EXP_W-1:0] deg_data;

    cur_var_count = hme_pkg::VAR_W'(1);
    cur_degree    = '0;
    clear_vector();
    random_items  = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Reset values first: one variable, zero degree.
    push_item(1'b0);
    push_item(1'b1);
    wait_drained();

    // A count of zero acts as one variable; full degree in the only exponent.
    write_register(hme_pkg::REG_VAR_COUNT, 8'd0);
    write_register(hme_pkg::REG_DEGREE, 8'd255);
    push_item(1'b0);
    wait_drained();

    // Sixteen variables at zero degree: the all-zero monomial, always last.
    write_register(hme_pkg::REG_VAR_COUNT, 8'd16);
    write_register(hme_pkg::REG_DEGREE, 8'd0);
    push_item(1'b0);
    push_item(1'b0);
    wait_drained();

    // Degree one at sixteen variables: the second and third steps search back,
    // the third over one zero exponent.
    write_register(hme_pkg::REG_DEGREE, 8'd1);
    push_item(1'b0);
    push_item(1'b0);
    push_item(1'b0);
    wait_drained();

    // All data bits set: the count saturates to sixteen, top degree.
    write_register(hme_pkg::REG_VAR_COUNT, 8'hFF);
    write_register(hme_pkg::REG_DEGREE, 8'd255);
    push_item(1'b0);
    push_item(1'b0);
    wait_drained();

    // Two variables at degree two: three monomials, then the wrap.
    write_register(hme_pkg::REG_VAR_COUNT, 8'd2);
    write_register(hme_pkg::REG_DEGREE, 8'd2);
    repeat (4) push_item(1'b0);
    wait_drained();

    // Three variables at degree two, with writes to undecoded indexes in
    // between that must not restart the walk, and a restart at the end.
    write_register(hme_pkg::REG_VAR_COUNT, 8'd3);
    repeat (3) push_item(1'b0);
    wait_drained();
    write_register(REG_SPARE_LO, 8'hAA);
    push_item(1'b0);
    wait_drained();
    write_register(REG_SPARE_HI, 8'h55);
    repeat (3) push_item(1'b0);
    push_item(1'b1);
    wait_drained();

    // Random part. Most phases use few variables and a small degree so that
    // the walk wraps often; some take extreme settings. The last stretch of
    // the run has no idling on either side.
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        vc_data  = 8'($urandom_range(0, 255));
        deg_data = $urandom_range(0, 1) ? 8'd255
                                        : hme_pkg::EXP_W'($urandom_range(0, 255));
      end else if (sel == 1) begin
        vc_data  = {3'($urandom_range(0, 7)), 5'd16};
        deg_data = hme_pkg::EXP_W'($urandom_range(0, 3));
      end else if (sel == 2) begin
        vc_data  = {3'($urandom_range(0, 7)), 5'($urandom_range(0, 1))};
        deg_data = hme_pkg::EXP_W'($urandom_range(0, 255));
      end else begin
        vc_data  = {3'($urandom_range(0, 7)), 5'($urandom_range(2, 5))};
        deg_data = hme_pkg::EXP_W'($urandom_range(0, 4));
      end

      which = $urandom_range(0, 3);
      if (which != 2) write_register(hme_pkg::REG_VAR_COUNT, vc_data);
      if (which != 1) write_register(hme_pkg::REG_DEGREE, deg_data);

      phase_items = $urandom_range(8, 30);
      if (random_items + phase_items >= RANDOM_ITEMS - 40) idle_mode = IDLE_OFF;
      else idle_mode = $urandom_range(IDLE_OFF, IDLE_HEAVY);

      for (int i = 0; i < phase_items; i++) begin
        // Halfway through some phases, pause for an undecoded write.
        if (which == 3 && i == phase_items / 2) begin
          wait_drained();
          write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                         8'($urandom_range(0, 255)));
        end
        push_item($urandom_range(0, 11) == 0);
      end
      random_items += phase_items;
      wait_drained();
    end

    if (mono_words_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", mono_words_q.size()));

    $display("Covered %0d requests, %0d result words (%0d flagged final), %0d register writes.",
             items_accepted, words_checked, last_words, writes_done);
    $display("Mismatches seen: %0d.", error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
